>>> hdl/dsp_pkg.sv
// Shared types, constants and helper functions for the dual-stick paddle mapper.
// No dependencies; compiled first.
package dsp_pkg;

    // Mapping modes
    localparam logic [1:0] MODE_AMBI   = 2'd0;
    localparam logic [1:0] MODE_LSTICK = 2'd1;
    localparam logic [1:0] MODE_RSTICK = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Active stick codes
    localparam logic STICK_RIGHT = 1'b0;
    localparam logic STICK_LEFT  = 1'b1;

    // Status byte qualification
    localparam logic [7:0] STATUS_MASK  = 8'hF0;
    localparam logic [7:0] STATUS_VALID = 8'h70;

    // Axis centre and pot offsets
    localparam logic [7:0] AXIS_CENTER = 8'd128;
    localparam logic [7:0] X_OFFSET    = 8'd130;
    localparam logic [7:0] Y_OFFSET    = 8'd128;

    // Scale 18/20 == 9/10; divide by 10 via reciprocal 6554/2^16 (exact for x <= 1152)
    localparam logic [3:0]  SCALE_NUM   = 4'd9;
    localparam logic [12:0] RECIP_TEN   = 13'd6554;
    localparam int          RECIP_SHIFT = 16;

    // Reset values
    localparam logic [7:0] THRESHOLD_RESET = 8'd64;
    localparam logic [7:0] BUTTONS_RESET   = 8'hFF;

    // buttons_low bits (active low)
    localparam int BTN_SELECT = 0;
    localparam int BTN_START  = 3;
    // buttons_high bits (active low)
    localparam int BTN_L2       = 0;
    localparam int BTN_R2       = 1;
    localparam int BTN_L1       = 2;
    localparam int BTN_R1       = 3;
    localparam int BTN_TRIANGLE = 4;
    localparam int BTN_CIRCLE   = 5;
    localparam int BTN_CROSS    = 6;
    localparam int BTN_SQUARE   = 7;

    // Keypad row bits
    localparam int ROW_START = 0;
    localparam int ROW_RESET = 1;
    localparam int ROW_PAUSE = 2;

    // Latched report contents
    typedef struct packed {
        logic [7:0] buttons_low;
        logic [7:0] buttons_high;
        logic [7:0] right_x;
        logic [7:0] right_y;
        logic [7:0] left_x;
        logic [7:0] left_y;
    } latch_t;

    // One result item
    typedef struct packed {
        logic [7:0] pot_a_x;
        logic [7:0] pot_a_y;
        logic [7:0] pot_b_x;
        logic [7:0] pot_b_y;
        logic       trigger_a_n;
        logic       trigger_b_n;
        logic [2:0] keypad_rows;
    } result_t;

    // Mapper outputs: result plus next state
    typedef struct packed {
        result_t    res;
        logic [1:0] mode_next;
        logic       active_next;
    } map_out_t;

    // Distance of an axis from centre, 0..128
    function automatic logic [7:0] deflection(input logic [7:0] v);
        logic [7:0] d;
        if (v >= AXIS_CENTER)
            d = v - AXIS_CENTER;
        else
            d = AXIS_CENTER - v;
        return d;
    endfunction

    // trunc((v-128)*18/20) + offset, modulo 256
    function automatic logic [7:0] scale_axis(input logic [7:0] v, input logic [7:0] offset);
        logic [7:0]  mag;
        logic [10:0] prod9;
        logic [23:0] prod;
        logic [7:0]  quot;
        logic [7:0]  dev;
        mag   = deflection(v);
        prod9 = 11'(mag) * 11'(SCALE_NUM);
        prod  = 24'(prod9) * 24'(RECIP_TEN);
        quot  = prod[RECIP_SHIFT +: 8];
        // below centre the deviation is negative; truncation toward zero on magnitude
        dev   = (v < AXIS_CENTER) ? (8'd0 - quot) : quot;
        return dev + offset;
    endfunction

endpackage

>>> hdl/dsp_in_if.sv
// Report channel: valid/ready handshake carrying one polled gamepad report.
// No package dependency.
interface dsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] report_status;
    logic [7:0] buttons_low;
    logic [7:0] buttons_high;
    logic [7:0] right_x;
    logic [7:0] right_y;
    logic [7:0] left_x;
    logic [7:0] left_y;

    modport source (
        output valid, report_status, buttons_low, buttons_high,
               right_x, right_y, left_x, left_y,
        input  ready
    );
    modport sink (
        input  valid, report_status, buttons_low, buttons_high,
               right_x, right_y, left_x, left_y,
        output ready
    );
endinterface

>>> hdl/dsp_out_if.sv
// Result channel: valid/ready handshake carrying pot values, triggers and keypad rows.
// No package dependency.
interface dsp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pot_a_x;
    logic [7:0] pot_a_y;
    logic [7:0] pot_b_x;
    logic [7:0] pot_b_y;
    logic       trigger_a_n;
    logic       trigger_b_n;
    logic [2:0] keypad_rows;

    modport source (
        output valid, pot_a_x, pot_a_y, pot_b_x, pot_b_y,
               trigger_a_n, trigger_b_n, keypad_rows,
        input  ready
    );
    modport sink (
        input  valid, pot_a_x, pot_a_y, pot_b_x, pot_b_y,
               trigger_a_n, trigger_b_n, keypad_rows,
        output ready
    );
endinterface

>>> hdl/dsp_latch.sv
// Input stage: accepts report transactions and latches valid analog reports.
// Depends on dsp_pkg and dsp_in_if.
module dsp_latch (
    input  logic           clk,
    input  logic           rst_n,
    dsp_in_if.sink         report,
    input  logic           advance,
    output logic           stage_valid,
    output dsp_pkg::latch_t latched
);
    import dsp_pkg::*;

    logic   valid_reg, valid_next;
    latch_t latch_reg, latch_next;
    logic   accept;
    logic   status_ok;

    // Stage frees up when its transaction moves to the result register
    assign report.ready = !valid_reg || advance;
    assign accept       = report.valid && report.ready;
    assign status_ok    = (report.report_status & STATUS_MASK) == STATUS_VALID;

    // Next valid flag and latch contents
    always_comb
    begin
        valid_next = valid_reg;
        latch_next = latch_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            if (status_ok)
            begin
                latch_next.buttons_low  = report.buttons_low;
                latch_next.buttons_high = report.buttons_high;
                latch_next.right_x      = report.right_x;
                latch_next.right_y      = report.right_y;
                latch_next.left_x       = report.left_x;
                latch_next.left_y       = report.left_y;
            end
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg              <= 1'b0;
            latch_reg.buttons_low  <= BUTTONS_RESET;
            latch_reg.buttons_high <= BUTTONS_RESET;
            latch_reg.right_x      <= 8'd0;
            latch_reg.right_y      <= 8'd0;
            latch_reg.left_x       <= 8'd0;
            latch_reg.left_y       <= 8'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            latch_reg <= latch_next;
        end
    end

    assign stage_valid = valid_reg;
    assign latched     = latch_reg;

endmodule

>>> hdl/dsp_map.sv
// Mapping logic: pots, triggers, keypad rows and next mode/active stick.
// Depends on dsp_pkg.
module dsp_map (
    input  dsp_pkg::latch_t   latched,
    input  logic [1:0]        mode,
    input  logic              active,
    input  logic [7:0]        threshold,
    output dsp_pkg::map_out_t map_out
);
    import dsp_pkg::*;

    logic [7:0] rx_sx, ry_sy, lx_sx, ly_sy;
    logic [7:0] r_defl, l_defl;
    logic       right_moved, left_moved;
    logic       sel;
    logic [7:0] b0, b1;
    logic [2:0] rows;
    logic       active_next;
    logic [7:0] pot_a_x, pot_a_y, pot_b_x, pot_b_y;
    logic [1:0] mode_next;
    logic       trig_a_n, trig_b_n;

    assign b0  = latched.buttons_low;
    assign b1  = latched.buttons_high;
    assign sel = !b0[BTN_SELECT];

    // Scaled axes
    assign rx_sx = scale_axis(latched.right_x, X_OFFSET);
    assign ry_sy = scale_axis(latched.right_y, Y_OFFSET);
    assign lx_sx = scale_axis(latched.left_x, X_OFFSET);
    assign ly_sy = scale_axis(latched.left_y, Y_OFFSET);

    // Larger deflection of each stick against the threshold
    always_comb
    begin
        r_defl = deflection(latched.right_x);
        if (deflection(latched.right_y) > r_defl)
            r_defl = deflection(latched.right_y);
        l_defl = deflection(latched.left_x);
        if (deflection(latched.left_y) > l_defl)
            l_defl = deflection(latched.left_y);
    end
    assign right_moved = r_defl > threshold;
    assign left_moved  = l_defl > threshold;

    // Active stick tracks only in ambidextrous mode (and the unused code); right stick wins
    always_comb
    begin
        active_next = active;
        if (mode == MODE_AMBI || mode == MODE_UNUSED)
        begin
            priority if (right_moved)
                active_next = STICK_RIGHT;
            else if (left_moved)
                active_next = STICK_LEFT;
            else
                active_next = active;
        end
    end

    // Pot routing per mode
    always_comb
    begin
        unique case (mode)
            MODE_RSTICK:
            begin
                pot_a_x = rx_sx;
                pot_a_y = ry_sy;
                pot_b_x = lx_sx;
                pot_b_y = ly_sy;
            end
            MODE_LSTICK:
            begin
                pot_a_x = lx_sx;
                pot_a_y = ly_sy;
                pot_b_x = rx_sx;
                pot_b_y = ry_sy;
            end
            default:
            begin
                // ambidextrous (the unused code behaves the same)
                if (active_next == STICK_RIGHT)
                begin
                    pot_a_x = rx_sx;
                    pot_a_y = ry_sy;
                end
                else
                begin
                    pot_a_x = lx_sx;
                    pot_a_y = ly_sy;
                end
                pot_b_x = pot_a_x;
                pot_b_y = pot_a_y;
            end
        endcase
    end

    // Mode change on Select plus face button
    always_comb
    begin
        mode_next = mode;
        if (sel)
        begin
            priority if (!b1[BTN_TRIANGLE])
                mode_next = MODE_AMBI;
            else if (!b1[BTN_SQUARE])
                mode_next = MODE_LSTICK;
            else if (!b1[BTN_CIRCLE])
                mode_next = MODE_RSTICK;
            else
                mode_next = mode;
        end
    end

    // Keypad rows
    always_comb
    begin
        rows = 3'd0;
        if (sel)
        begin
            rows[ROW_RESET] = !b0[BTN_START];
            rows[ROW_PAUSE] = !b1[BTN_CROSS];
        end
        else
        begin
            rows[ROW_START] = !b0[BTN_START];
        end
    end

    // Triggers, active low
    assign trig_a_n = !(!sel && (!b1[BTN_L1] || !b1[BTN_R1] || !b1[BTN_TRIANGLE]));
    assign trig_b_n = !(!sel && (!b1[BTN_L2] || !b1[BTN_R2] || !b1[BTN_CROSS]));

    // Pack the mapper outputs
    always_comb
    begin
        map_out.res.pot_a_x     = pot_a_x;
        map_out.res.pot_a_y     = pot_a_y;
        map_out.res.pot_b_x     = pot_b_x;
        map_out.res.pot_b_y     = pot_b_y;
        map_out.res.trigger_a_n = trig_a_n;
        map_out.res.trigger_b_n = trig_b_n;
        map_out.res.keypad_rows = rows;
        map_out.mode_next       = mode_next;
        map_out.active_next     = active_next;
    end

endmodule

>>> hdl/dual_stick_to_paddle_mapper_core.sv
// Dual-stick to paddle mapper, top level: latch stage, mapping logic, result register.
// Depends on dsp_pkg, dsp_in_if, dsp_out_if, dsp_latch, dsp_map.

// Takes one gamepad report transaction per clock while the result side keeps pace and
// returns one result transaction per report. The first register stage latches the
// report (buttons and axes are replaced only when the status high nibble is 7); the
// mapping runs combinationally from that latch, the current mode and active stick into
// the output register, where mode and active stick update and the result is offered.
// The output register and the latch stage each hold one transaction, so one more
// transaction is accepted while a result waits; after that the input stalls until the
// result is taken. The stick threshold resets to 64; the user must write it through
// cfg_we/cfg_wdata only while the block is idle. The block does not enforce this.
module dual_stick_to_paddle_mapper_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    dsp_in_if.sink     report,
    dsp_out_if.source  result
);
    import dsp_pkg::*;

    logic       stage_valid;
    logic       advance;
    latch_t     latched;
    map_out_t   map_out;

    logic [7:0] threshold_reg;
    logic [1:0] mode_reg;
    logic       active_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;

    // Latched transaction moves on when the output register is free or drained
    assign advance = stage_valid && (!out_valid_reg || result.ready);

    dsp_latch u_latch (
        .clk         (clk),
        .rst_n       (rst_n),
        .report      (report),
        .advance     (advance),
        .stage_valid (stage_valid),
        .latched     (latched)
    );

    dsp_map u_map (
        .latched   (latched),
        .mode      (mode_reg),
        .active    (active_reg),
        .threshold (threshold_reg),
        .map_out   (map_out)
    );

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            threshold_reg <= THRESHOLD_RESET;
        else if (cfg_we)
            threshold_reg <= cfg_wdata;
    end

    // Mode and active stick update as a transaction passes the mapper
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_AMBI;
            active_reg <= STICK_RIGHT;
        end
        else if (advance)
        begin
            mode_reg   <= map_out.mode_next;
            active_reg <= map_out.active_next;
        end
    end

    // Output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= map_out.res;
    end

    assign result.valid       = out_valid_reg;
    assign result.pot_a_x     = out_reg.pot_a_x;
    assign result.pot_a_y     = out_reg.pot_a_y;
    assign result.pot_b_x     = out_reg.pot_b_x;
    assign result.pot_b_y     = out_reg.pot_b_y;
    assign result.trigger_a_n = out_reg.trigger_a_n;
    assign result.trigger_b_n = out_reg.trigger_b_n;
    assign result.keypad_rows = out_reg.keypad_rows;

    // The unused mode code is never entered
    a_mode_reachable: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != MODE_UNUSED)
        else $error("mapping mode reached unused code");

    // Active stick only moves while a transaction passes in ambidextrous mode
    a_active_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!advance || mode_reg != MODE_AMBI) |=> $stable(active_reg))
        else $error("active stick changed outside ambidextrous mapping");

    // A latched transaction is never dropped while the result side stalls
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid && !advance) |=> stage_valid)
        else $error("latched transaction lost");

    // A waiting result is not overwritten
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |-> !advance)
        else $error("result register overwritten while stalled");

endmodule
